// ----- rtl/bbc_pkg.sv -----
// Shared types, character codes and the bracket classifier for the
// bracket balance checker. No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int CHAR_W              = 8;

    localparam logic [CHAR_W-1:0] CHAR_PAREN_OPEN   = 8'h28; // (
    localparam logic [CHAR_W-1:0] CHAR_PAREN_CLOSE  = 8'h29; // )
    localparam logic [CHAR_W-1:0] CHAR_SQUARE_OPEN  = 8'h5B; // [
    localparam logic [CHAR_W-1:0] CHAR_SQUARE_CLOSE = 8'h5D; // ]
    localparam logic [CHAR_W-1:0] CHAR_CURLY_OPEN   = 8'h7B; // {
    localparam logic [CHAR_W-1:0] CHAR_CURLY_CLOSE  = 8'h7D; // }

    typedef enum logic [1:0] {
        BR_NONE   = 2'd0,
        BR_PAREN  = 2'd1,
        BR_SQUARE = 2'd2,
        BR_CURLY  = 2'd3
    } br_type_t;

    typedef struct packed {
        logic     is_open;
        logic     is_close;
        br_type_t kind;
    } char_class_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t r;
        r = '{is_open: 1'b0, is_close: 1'b0, kind: BR_NONE};
        unique case (c)
            CHAR_PAREN_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: BR_PAREN};
            CHAR_SQUARE_OPEN:  r = '{is_open: 1'b1, is_close: 1'b0, kind: BR_SQUARE};
            CHAR_CURLY_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: BR_CURLY};
            CHAR_PAREN_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: BR_PAREN};
            CHAR_SQUARE_CLOSE: r = '{is_open: 1'b0, is_close: 1'b1, kind: BR_SQUARE};
            CHAR_CURLY_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: BR_CURLY};
            default:           r = '{is_open: 1'b0, is_close: 1'b0, kind: BR_NONE};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/bbc_stack_ram.sv -----
// Bracket type stack storage: one write port, one read port, registered read.
// Depends on bbc_pkg for the entry type.
`timescale 1ns / 1ps

module bbc_stack_ram #(
    parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  bbc_pkg::br_type_t wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output bbc_pkg::br_type_t rd_data
);

    bbc_pkg::br_type_t mem [STACK_DEPTH];
    bbc_pkg::br_type_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data unless a new read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bracket_balance_checker_core.sv -----
// Bracket balance checker: one character per transfer, verdict per string.
// Verdict path: the stage 2 register, then the output register.
// Throughput: one character per cycle while stage 2 is not stalled, set by the
//   push/pop on the stack RAM (write and top-entry read at accept).
// Reset: rst_n asynchronous, active low; clears stack level, failure flag and
//   pipeline valids. Stack RAM contents are not cleared and need no sweep.
// Depends on bbc_pkg and bbc_stack_ram.
`timescale 1ns / 1ps

module bracket_balance_checker_core #(
    parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    // character stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_string
    // verdict stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] balanced, [7:1] zero
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);

    // ------------------------------------------------------------------
    // Stage 1 (accept): classify, update the stack level, push into the
    // RAM, and issue the read of the top entry for a pop. A pop always
    // reads an address written by an earlier accepted character, so the
    // registered read sees the push of the previous character and no
    // forwarding path is needed.
    // ------------------------------------------------------------------
    logic                 accept;
    logic                 s2_adv;
    bbc_pkg::char_class_t cls;
    logic                 at_empty;
    logic                 at_full;
    logic                 push_ok;
    logic                 pop_ok;
    logic                 fail_early;
    logic [LW-1:0]        level_reg;
    logic [LW-1:0]        level_next;
    logic [LW-1:0]        level_after;
    logic [LW-1:0]        level_dec;

    // Stage 2: compare popped type, fold into sticky failure.
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic                 s2_check_reg;
    logic                 s2_fail_reg;
    logic                 s2_zero_reg;
    bbc_pkg::br_type_t    s2_kind_reg;
    bbc_pkg::br_type_t    top_kind;
    logic                 failed_reg;
    logic                 failed_next;
    logic                 fail_now;
    logic                 fail_total;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 balanced_reg;
    logic                 balanced_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = s2_adv;

    assign cls        = bbc_pkg::classify(s_tdata);
    assign at_empty   = (level_reg == '0);
    assign at_full    = (level_reg == LW'(STACK_DEPTH));
    assign push_ok    = cls.is_open && !at_full;
    assign pop_ok     = cls.is_close && !at_empty;
    // Non-bracket, overflow on open, or close on an empty stack.
    assign fail_early = (!cls.is_open && !cls.is_close)
                        || (cls.is_open && at_full)
                        || (cls.is_close && at_empty);
    assign level_dec  = level_reg - LW'(1);

    always_comb
    begin
        level_after = level_reg;
        if (push_ok)
        begin
            level_after = level_reg + LW'(1);
        end
        else if (pop_ok)
        begin
            level_after = level_dec;
        end
        level_next = level_reg;
        if (accept)
        begin
            level_next = s_tlast ? '0 : level_after;
        end
    end

    bbc_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (accept && push_ok),
        .wr_addr (level_reg[AW-1:0]),
        .wr_data (cls.kind),
        .rd_en   (accept && pop_ok),
        .rd_addr (level_dec[AW-1:0]),
        .rd_data (top_kind)
    );

    // ------------------------------------------------------------------
    // Stage 2 advances unless it holds a final character whose verdict
    // cannot enter a still-occupied output register.
    // ------------------------------------------------------------------
    assign s2_adv = !s2_valid_reg || !s2_last_reg || !out_valid_reg || m_tready;

    assign fail_now   = s2_fail_reg || (s2_check_reg && (top_kind != s2_kind_reg));
    assign fail_total = failed_reg || fail_now;

    always_comb
    begin
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !m_tready;
        balanced_next  = balanced_reg;
        if (s2_valid_reg && s2_adv)
        begin
            if (s2_last_reg)
            begin
                // Report and clear for the next string.
                failed_next    = 1'b0;
                out_valid_next = 1'b1;
                balanced_next  = !fail_total && s2_zero_reg;
            end
            else
            begin
                failed_next = fail_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
            if (s2_adv)
            begin
                s2_valid_reg <= accept;
            end
        end
    end

    // Stage 2 payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_last_reg  <= s_tlast;
            s2_check_reg <= pop_ok;
            s2_fail_reg  <= fail_early;
            s2_zero_reg  <= (level_after == '0);
            s2_kind_reg  <= cls.kind;
        end
        balanced_reg <= balanced_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, balanced_reg};

`ifndef SYNTHESIS
    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_level_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (level_reg == '0))
        else $error("stack level not cleared after final character");

    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("verdict without a final character");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> (s2_valid_reg && $stable(top_kind)
                                       && $stable(s2_kind_reg)))
        else $error("stage 2 lost its item while stalled");
`endif

endmodule
